// ----- design/sukt_pkg.sv -----
package sukt_pkg;

   // fixed field widths
   localparam int KEY_W    = 64;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // default table shape
   localparam int DEF_DEPTH     = 64;
   localparam int DEF_KEY_BYTES = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // per-cycle control seen by every cell of the ring
   typedef struct packed {
      logic shift;
   } cell_ctrl_type;

endpackage

// ----- design/sukt_cell.sv -----
module sukt_cell
   import sukt_pkg::*;
(
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [KEY_W-1:0]     key_in,
   output logic [KEY_W-1:0]     key_out
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in_w;

   // take the neighbor's key on a shift, hold otherwise
   assign key_in_w = ctrl.shift ? key_in : key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in_w;
   end

   assign key_out = key_ff;

endmodule

// ----- design/sorted_unique_key_table_top.sv -----
// channel   dir  handshake             payload
// req_      in   req_tvalid/tready     tuser: mode; tdata: key, index
// rsp_      out  rsp_tvalid/tready     tdata: status, position, key_out, entry_count
//
// insert, delete and read in range run accept, scan and finish before the next accept:
//   the accept step, a scan that rotates the cell ring once past the head, the finish step
// out-of-range delete/read and the unused mode go from accept straight to finish, no rotation
// the ring rotation (one entry past the head comparator per cycle) sets the rate
// reset clears the entry count and the handshake state; cell contents are not cleared,
//   entries at or above the count are never used
// a stalled result waits in the output register; the finish cycle holds until it drains
module sorted_unique_key_table_top
   import sukt_pkg::*;
#(
   parameter int DEPTH     = DEF_DEPTH,
   parameter int KEY_BYTES = DEF_KEY_BYTES,
   localparam int IDX_W    = $clog2(DEPTH),
   localparam int CNT_W    = $clog2(DEPTH + 1),
   localparam int REQ_W    = ((KEY_W + IDX_W + 7) / 8) * 8,
   localparam int RSP_W    = ((STATUS_W + IDX_W + KEY_W + CNT_W + 7) / 8) * 8
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // key, index, zero pad
   input  logic [MODE_W-1:0] req_tuser,   // mode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // status, position, key_out, entry_count, zero pad
);

   // keeps only the low KEY_BYTES bytes of a key
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

   // request fields
   mode_type             req_mode;
   logic [KEY_W-1:0]     req_key;
   logic [IDX_W-1:0]     req_index;
   logic                 req_accept;
   logic                 req_bad_index;

   assign req_mode      = mode_type'(req_tuser);
   assign req_key       = req_tdata[KEY_W-1:0] & KEY_MASK;
   assign req_index     = req_tdata[KEY_W +: IDX_W];
   assign req_accept    = req_tvalid && req_tready;

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 placed_ff, placed_in;     // insertion point already passed
   logic                 shifting_ff, shifting_in; // key written, later entries move up
   logic                 rsp_valid_ff, rsp_valid_in;

   // operation payload
   mode_type             op_ff, op_in;
   logic [KEY_W-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     t_ff, t_in;               // table index now at the ring head
   logic [KEY_W-1:0]     carry_ff, carry_in;       // entry displaced by the insert

   // pending result
   status_type           pend_status_ff, pend_status_in;
   logic [IDX_W-1:0]     pend_pos_ff, pend_pos_in;
   logic [KEY_W-1:0]     pend_key_ff, pend_key_in;
   logic [CNT_W-1:0]     pend_count_ff, pend_count_in;

   // output register
   status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // cell ring
   cell_ctrl_type        cell_ctrl;
   logic [KEY_W-1:0]     cell_key [DEPTH];
   logic [KEY_W-1:0]     feed;
   logic [KEY_W-1:0]     head_key;
   logic [KEY_W-1:0]     next_key;

   assign head_key = cell_key[0];
   assign next_key = cell_key[1];

   // each cell takes its upper neighbor's key; the top cell takes the feed, which
   // becomes entry t after one full rotation
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0] cell_src;
      if (g == DEPTH - 1) begin : g_top
         assign cell_src = feed;
      end else begin : g_mid
         assign cell_src = cell_key[g + 1];
      end
      sukt_cell u_cell (
         .clock   (clock),
         .ctrl    (cell_ctrl),
         .key_in  (cell_src),
         .key_out (cell_key[g])
      );
   end

   // head comparisons
   logic slot_free;
   logic last_step;
   logic table_full;
   logic head_valid;
   logic at_place;
   logic dup_hit;

   assign slot_free     = !rsp_valid_ff || rsp_tready;
   assign last_step     = (t_ff == IDX_W'(DEPTH - 1));
   assign table_full    = (count_ff == CNT_W'(DEPTH));
   assign head_valid    = (CNT_W'(t_ff) < count_ff);
   assign at_place      = !placed_ff && (!head_valid || head_key >= k_ff);
   assign dup_hit       = at_place && head_valid && (head_key == k_ff);
   assign req_bad_index = (CNT_W'(req_index) >= count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_INSERT ||
                   ((req_mode == MODE_DELETE || req_mode == MODE_READ) && !req_bad_index)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready      = 1'b0;
      cell_ctrl.shift = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready      = 1'b1;
         ST_SCAN:   cell_ctrl.shift = 1'b1;
         ST_FINISH: ;
         default:   ;
      endcase
   end

   // datapath
   always_comb begin
      count_in       = count_ff;
      placed_in      = placed_ff;
      shifting_in    = shifting_ff;
      op_in          = op_ff;
      k_in           = k_ff;
      idx_in         = idx_ff;
      t_in           = t_ff;
      carry_in       = head_key;
      pend_status_in = pend_status_ff;
      pend_pos_in    = pend_pos_ff;
      pend_key_in    = pend_key_ff;
      pend_count_in  = pend_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_count_in   = rsp_count_ff;
      feed           = head_key;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in          = req_mode;
               k_in           = req_key;
               idx_in         = req_index;
               t_in           = '0;
               placed_in      = 1'b0;
               shifting_in    = 1'b0;
               pend_status_in = STAT_DONE;
               pend_pos_in    = req_index;
               pend_key_in    = '0;
               pend_count_in  = count_ff;
               case (req_mode)
                  MODE_INSERT: begin
                     // stays full unless a duplicate or, with room in the table, a place is found
                     pend_status_in = STAT_FULL;
                     pend_pos_in    = '0;
                     pend_key_in    = req_key;
                  end
                  MODE_DELETE: begin
                     if (req_bad_index) begin
                        pend_status_in = STAT_RANGE;
                     end else begin
                        pend_count_in = count_ff - 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (req_bad_index) begin
                        pend_status_in = STAT_RANGE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            t_in = t_ff + 1'b1;
            case (op_ff)
               MODE_INSERT: begin
                  if (at_place) begin
                     placed_in = 1'b1;
                     if (dup_hit) begin
                        pend_status_in = STAT_DUP;
                        pend_pos_in    = t_ff;
                     end else if (!table_full) begin
                        pend_status_in = STAT_DONE;
                        pend_pos_in    = t_ff;
                        pend_count_in  = count_ff + 1'b1;
                        shifting_in    = 1'b1;
                        feed           = k_ff;
                     end
                  end else if (shifting_ff) begin
                     feed = carry_ff;
                  end
               end
               MODE_DELETE: begin
                  if (t_ff == idx_ff) begin
                     pend_key_in = head_key;
                  end
                  // close the gap: entry t takes entry t + 1
                  if (t_ff >= idx_ff) begin
                     feed = next_key;
                  end
               end
               MODE_READ: begin
                  if (t_ff == idx_ff) begin
                     pend_key_in = head_key;
                  end
               end
               default: ;
            endcase
         end
         ST_FINISH: begin
            if (slot_free) begin
               count_in      = pend_count_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_pos_in    = pend_pos_ff;
               rsp_key_in    = pend_key_ff;
               rsp_count_in  = pend_count_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         placed_ff    <= 1'b0;
         shifting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         placed_ff    <= placed_in;
         shifting_ff  <= shifting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      k_ff           <= k_in;
      idx_ff         <= idx_in;
      t_ff           <= t_in;
      carry_ff       <= carry_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
      pend_key_ff    <= pend_key_in;
      pend_count_ff  <= pend_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_key_ff, rsp_pos_ff, rsp_status_ff});

   // count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // an accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // shifting only after the insertion point has been passed
   a_shift_after_place: assert property (@(posedge clock) disable iff (reset)
      shifting_ff |-> placed_ff)
      else $error("insert shifting without a place");

   // a new result only comes out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish");

   // a successful insert grows the table by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && slot_free && op_ff == MODE_INSERT &&
       pend_status_ff == STAT_DONE) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the table");

endmodule
